### hw/rtl/tsq_pkg.sv
// tsq_pkg: shared types, sizes and codes for the two-stack queue
`timescale 1ns / 1ps
package tsq_pkg;

  localparam int DEPTH  = 128;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // operation codes of the func field
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               enq;
    logic               rd;
    logic               pop;
    logic signed [31:0] value;
  } cmd_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] in_cnt;
    logic [CNT_W-1:0] out_cnt;
    logic             busy;
  } bk_stat_t;

endpackage

### hw/rtl/tsq_front.sv
// tsq_front: input acceptance, operation decode and two-entry command queue
`timescale 1ns / 1ps
module tsq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsq_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output tsq_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  tsq_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  tsq_pkg::cmd_t dec;
  logic          push;
  logic          pop;

  // decode func, unused selector becomes a no-op
  always_comb begin
    dec       = '0;
    dec.value = in_item.value;
    unique case (in_item.func)
      tsq_pkg::OP_ENQ: begin
        dec.enq = 1'b1;
      end
      tsq_pkg::OP_DEQ: begin
        dec.rd  = 1'b1;
        dec.pop = 1'b1;
      end
      tsq_pkg::OP_PEEK: begin
        dec.rd = 1'b1;
      end
      default: begin
        dec.enq = 1'b0;
      end
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### hw/rtl/tsq_back.sv
// tsq_back: the two stack memories, transfer sequencer and result register
`timescale 1ns / 1ps
module tsq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  tsq_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_valid,
  input  logic               out_stall,
  output tsq_pkg::out_item_t out_item,
  output tsq_pkg::bk_stat_t  stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_XFER  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_RD    = 2'd3;

  localparam logic [tsq_pkg::CNT_W-1:0] CNT_ONE  = tsq_pkg::CNT_W'(1);
  localparam logic [tsq_pkg::CNT_W-1:0] CNT_FULL = tsq_pkg::CNT_W'(tsq_pkg::DEPTH);

  logic [31:0] in_mem  [tsq_pkg::DEPTH];
  logic [31:0] out_mem [tsq_pkg::DEPTH];

  logic [1:0]                state_r, state_nxt;
  logic [tsq_pkg::CNT_W-1:0] in_cnt_r, in_cnt_nxt;
  logic [tsq_pkg::CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  tsq_pkg::out_item_t        out_item_r;
  logic [31:0]               in_rd_data_r;
  logic [31:0]               out_rd_data_r;

  logic                      out_free;
  logic                      load;
  tsq_pkg::out_item_t        load_item;
  logic [tsq_pkg::CNT_W-1:0] in_top;
  logic [tsq_pkg::CNT_W-1:0] out_top;
  logic                      in_we, in_re, out_we, out_re;

  assign out_free = !out_valid_r || !out_stall;
  assign in_top   = in_cnt_r - CNT_ONE;
  assign out_top  = out_cnt_r - CNT_ONE;

  always_comb begin
    state_nxt   = state_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    rd_pend_nxt = 1'b0;
    cmd_take    = 1'b0;
    load        = 1'b0;
    load_item   = '0;
    in_we       = 1'b0;
    in_re       = 1'b0;
    out_we      = 1'b0;
    out_re      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          if (cmd.enq) begin
            cmd_take = 1'b1;
            load     = 1'b1;
            if (in_cnt_r == CNT_FULL) begin
              load_item.status = tsq_pkg::ST_OVF;
            end else begin
              in_we      = 1'b1;
              in_cnt_nxt = in_cnt_r + CNT_ONE;
            end
          end else if (cmd.rd) begin
            if (out_cnt_r != '0) begin
              out_re    = 1'b1;
              state_nxt = S_RD;
            end else if (in_cnt_r != '0) begin
              state_nxt = S_XFER;
            end else begin
              cmd_take         = 1'b1;
              load             = 1'b1;
              load_item.status = tsq_pkg::ST_EMPTY;
            end
          end else begin
            cmd_take = 1'b1;
            load     = 1'b1;
          end
        end
      end
      S_XFER: begin
        // read pipelined one entry ahead of the write
        if (in_cnt_r != '0) begin
          in_re       = 1'b1;
          in_cnt_nxt  = in_top;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          out_we      = 1'b1;
          out_cnt_nxt = out_cnt_r + CNT_ONE;
        end
        if (in_cnt_r == '0 && !rd_pend_r) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        out_re    = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd_take       = 1'b1;
        load           = 1'b1;
        load_item.data = out_rd_data_r;
        if (cmd.pop) begin
          out_cnt_nxt = out_top;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= load_item;
    end
  end

  // input stack memory
  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[in_cnt_r[tsq_pkg::ADDR_W-1:0]] <= cmd.value;
    end
    if (in_re) begin
      in_rd_data_r <= in_mem[in_top[tsq_pkg::ADDR_W-1:0]];
    end
  end

  // output stack memory
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_cnt_r[tsq_pkg::ADDR_W-1:0]] <= in_rd_data_r;
    end
    if (out_re) begin
      out_rd_data_r <= out_mem[out_top[tsq_pkg::ADDR_W-1:0]];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign stat.in_cnt  = in_cnt_r;
  assign stat.out_cnt = out_cnt_r;
  assign stat.busy    = (state_r != S_IDLE);

endmodule

### hw/rtl/two_stack_queue.sv
// two_stack_queue: top level of the fifo queue built from two stacks
// results: enqueue, overflow, empty and no-op results go straight to the result register;
//   dequeue or peek with data in the output stack first reads it through the
//   registered read port; with the output stack empty, n queued entries are moved first
// throughput: one enqueue per cycle while the back is idle and the output is not stalled;
//   a dequeue or peek holds the back busy until its read is done; each entry moves across once
// reset: rst_n synchronous active low, empties both stacks, no clearing pass
`timescale 1ns / 1ps
module two_stack_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tsq_pkg::out_item_t out_item
);

  // front to back command queue handshake
  logic              cmd_valid;
  logic              cmd_take;
  tsq_pkg::cmd_t     cmd;
  tsq_pkg::bk_stat_t stat;

  // front: takes items, decodes func, buffers up to two commands
  tsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: stack memories, refill sequencer and result register
  tsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .stat      (stat)
  );

  // stack fill levels stay within capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.in_cnt <= tsq_pkg::CNT_W'(tsq_pkg::DEPTH)) &&
    (stat.out_cnt <= tsq_pkg::CNT_W'(tsq_pkg::DEPTH)))
    else $error("stack count beyond capacity");

  // an empty result only while both stacks hold nothing
  a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == tsq_pkg::ST_EMPTY) |->
    (stat.in_cnt == '0 && stat.out_cnt == '0))
    else $error("empty status with queued entries");

  // the back only works on a command that is still held by the front
  a_busy_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> cmd_valid)
    else $error("back busy without a pending command");

  // a refill from an empty output stack only starts with entries in the input stack
  a_xfer_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(stat.busy) && stat.out_cnt == '0) |-> $past(stat.in_cnt) != '0)
    else $error("refill started with empty input stack");

endmodule

### tb/tb_two_stack_queue.sv
// tb_two_stack_queue: self-checking bench for the two-stack queue with random flow control
`timescale 1ns / 1ps
module tb_two_stack_queue;

  // func code 3 is not an operation: the block answers ok with zero data
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_AT_SENT = 400;      // sent count that starts the long receiver hold
  localparam int HOLD_CYCLES  = 400;      // length of that hold, in cycles
  localparam int SETTLE_WAIT  = 200;      // idle wait after the last answer before the verdict
  localparam int LIMIT_CYCLES = 200000;

  // one pending item for the driver; wait_idle holds it back until all answers are in
  typedef struct {
    tsq_pkg::in_item_t item;
    bit                wait_idle;
  } op_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tsq_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tsq_pkg::out_item_t out_item;

  op_entry_t          ops_to_send[$];
  tsq_pkg::out_item_t answers_due[$];

  // shadow of the two stacks
  logic signed [31:0] mdl_in_stk [tsq_pkg::DEPTH];
  logic signed [31:0] mdl_out_stk[tsq_pkg::DEPTH];
  int                 mdl_in_cnt = 0;
  int                 mdl_out_cnt = 0;

  int err_cnt = 0;
  int sent_cnt = 0;
  int cycle_cnt = 0;

  two_stack_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // applies one accepted item to the shadow stacks and returns the answer it earns
  function automatic tsq_pkg::out_item_t predict_answer(input tsq_pkg::in_item_t it);
    tsq_pkg::out_item_t r;
    r.data   = '0;
    r.status = tsq_pkg::ST_OK;
    case (it.func)
      tsq_pkg::OP_ENQ: begin
        // full input stack drops the value even if the output stack has room
        if (mdl_in_cnt >= tsq_pkg::DEPTH) begin
          r.status = tsq_pkg::ST_OVF;
        end else begin
          mdl_in_stk[mdl_in_cnt] = it.value;
          mdl_in_cnt++;
        end
      end
      tsq_pkg::OP_DEQ, tsq_pkg::OP_PEEK: begin
        // refill only from an empty output stack, reversing the order
        if (mdl_out_cnt == 0) begin
          while (mdl_in_cnt != 0) begin
            mdl_in_cnt--;
            mdl_out_stk[mdl_out_cnt] = mdl_in_stk[mdl_in_cnt];
            mdl_out_cnt++;
          end
        end
        if (mdl_out_cnt == 0) begin
          r.status = tsq_pkg::ST_EMPTY;
        end else begin
          r.data = mdl_out_stk[mdl_out_cnt - 1];
          if (it.func == tsq_pkg::OP_DEQ) mdl_out_cnt--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // value with the field extremes mixed in among fully random words
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [1:0] f, input logic signed [31:0] v, input bit hold_back);
    op_entry_t e;
    e.item.func  = f;
    e.item.value = v;
    e.wait_idle  = hold_back;
    ops_to_send.push_back(e);
  endtask

  // driver: bursts of items with random gaps; prediction happens at acceptance
  always @(posedge clk) begin : driver
    logic              nxt_valid;
    tsq_pkg::in_item_t nxt_item;
    int                gap_left;
    int                burst_left;
    op_entry_t         e;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      nxt_valid = in_valid;
      nxt_item  = in_item;
      if (in_valid && !in_stall) begin
        answers_due.push_back(predict_answer(in_item));
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (ops_to_send.size() != 0 &&
                     (!ops_to_send[0].wait_idle || answers_due.size() == 0)) begin
          e         = ops_to_send.pop_front();
          nxt_item  = e.item;
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // some bursts run long with no gap, others are short and choppy
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  // monitor: checks each result against the oldest answer due, and drives stall
  always @(posedge clk) begin : monitor
    tsq_pkg::out_item_t want;
    logic               nxt_stall;
    int                 hold_left;
    bit                 hold_done;
    int                 mode_left;
    int                 mode;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      mode_left = 0;
      mode      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: data %0d status %0d", out_item.data, out_item.status);
          err_cnt++;
        end else begin
          want = answers_due.pop_front();
          if (out_item.data !== want.data) begin
            $error("data mismatch: expected %0d, actual %0d", want.data, out_item.data);
            err_cnt++;
          end
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_item.status);
            err_cnt++;
          end
        end
      end
      // one long hold while the sender keeps going, so the block backs up
      if (!hold_done && sent_cnt >= HOLD_AT_SENT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        case (mode)
          0: nxt_stall = 1'b0;                              // free flowing
          1: nxt_stall = ($urandom_range(0, 9) < 3);         // light random
          2: nxt_stall = (cycle_cnt % 3 == 0);               // periodic
          default: nxt_stall = ($urandom_range(0, 9) < 7);   // heavy random
        endcase
      end
      out_stall <= nxt_stall;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int n_rand;
    int len;
    int kind;
    int i;
    logic [1:0] f;

    // directed: empty queue, unused selector, extremes, transfer while input has entries
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_PEEK, $urandom, 1'b0);
    add_op(OP_NONE,          $urandom, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  32'sh7fff_ffff, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  32'sh8000_0000, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  32'sh0000_0000, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  -32'sd1, 1'b0);
    add_op(tsq_pkg::OP_PEEK, 32'sh0000_0000, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  -32'sd1, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  32'sh5a5a_a5a5, 1'b0);
    add_op(tsq_pkg::OP_PEEK, 32'sh7fff_ffff, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  32'sh8000_0000, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_PEEK, $urandom, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_PEEK, $urandom, 1'b0);
    add_op(OP_NONE,          -32'sd1, 1'b0);
    add_op(tsq_pkg::OP_ENQ,  $urandom, 1'b0);
    add_op(tsq_pkg::OP_DEQ,  $urandom, 1'b0);

    // random: mostly well-formed fill and drain runs, some noise
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = $urandom_range(10, 60);
      end else if (kind <= 6) begin
        len = $urandom_range(100, 140);
      end else if (kind <= 8) begin
        len = $urandom_range(20, 80);
      end else begin
        len = $urandom_range(5, 20);
      end
      for (i = 0; i < len; i++) begin
        if (kind <= 4) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: f = tsq_pkg::OP_ENQ;
            9, 10, 11, 12, 13, 14:     f = tsq_pkg::OP_DEQ;
            15, 16, 17, 18:            f = tsq_pkg::OP_PEEK;
            default:                   f = OP_NONE;
          endcase
        end else if (kind <= 6) begin
          // long enqueue runs push the input stack into overflow
          f = ($urandom_range(0, 19) == 0) ? tsq_pkg::OP_PEEK : tsq_pkg::OP_ENQ;
        end else if (kind <= 8) begin
          f = ($urandom_range(0, 3) == 0) ? tsq_pkg::OP_PEEK : tsq_pkg::OP_DEQ;
        end else begin
          f = 2'($urandom_range(0, 3));
        end
        // sender drains all answers at the start of the random part and 100 items past midway
        add_op(f, pick_value(), (n_rand == 0) || (n_rand == RANDOM_ITEMS / 2 + 100));
        n_rand++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_front.sv
hw/rtl/tsq_back.sv
hw/rtl/two_stack_queue.sv
tb/tb_two_stack_queue.sv
